>>> hdl/nfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared types, command codes and result sequences of the NOR flash
// program/erase sequencer.
// ----------------------------------------------------------------------------
package nfps_pkg;

	localparam int NFPS_ADDR_BITS = 21;
	localparam int ADDR_W         = 21;
	localparam int LIMIT_W        = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd4000;

	// input commands
	localparam logic [1:0] CMD_PROG  = 2'd0;
	localparam logic [1:0] CMD_ERASE = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;
	localparam logic [1:0] CMD_REPLY = 2'd3;

	// result kinds
	localparam logic [1:0] K_WRITE = 2'd0;
	localparam logic [1:0] K_READ  = 2'd1;
	localparam logic [1:0] K_DONE  = 2'd2;

	// completion status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FAIL    = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// flash command bytes and addresses
	localparam logic [ADDR_W-1:0] A_UNLOCK1 = 21'h000555;
	localparam logic [ADDR_W-1:0] A_UNLOCK2 = 21'h0002AA;
	localparam logic [ADDR_W-1:0] A_ZERO    = 21'h000000;
	localparam logic [7:0] D_UNLOCK1  = 8'hAA;
	localparam logic [7:0] D_UNLOCK2  = 8'h55;
	localparam logic [7:0] D_PROGRAM  = 8'hA0;
	localparam logic [7:0] D_ERASE    = 8'h80;
	localparam logic [7:0] D_SECTOR   = 8'h30;
	localparam logic [7:0] D_RESET    = 8'hF0;
	localparam logic [7:0] D_ERASED   = 8'hFF;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PROG_POLL,
		PH_PROG_LAST,
		PH_ERASE_POLL
	} phase_t;

	// result sequences that one item can cause
	typedef enum logic [2:0] {
		SEQ_DONE,      // completion only
		SEQ_READ,      // one status read
		SEQ_WRDONE,    // reset write, then completion
		SEQ_PROG,      // unlock, program write, first read
		SEQ_ERASE_RD,  // reset, erase sequence, first read
		SEQ_ERASE_TO   // reset, erase sequence, timeout completion
	} seq_t;

	typedef struct packed {
		logic              vld;
		logic              emit;   // item causes at least one result
		seq_t              seq;
		logic [1:0]        status;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} req_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic [1:0]        status;
	} res_t;

	function automatic logic [3:0] seq_len(input seq_t seq);
		logic [3:0] n;
		unique case (seq)
			SEQ_DONE:     n = 4'd1;
			SEQ_READ:     n = 4'd1;
			SEQ_WRDONE:   n = 4'd2;
			SEQ_PROG:     n = 4'd5;
			SEQ_ERASE_RD: n = 4'd8;
			SEQ_ERASE_TO: n = 4'd8;
			default:      n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic res_t wr(input logic [ADDR_W-1:0] a, input logic [7:0] d);
		res_t r;
		r.kind   = K_WRITE;
		r.addr   = a;
		r.data   = d;
		r.status = ST_OK;
		return r;
	endfunction

	function automatic res_t seq_entry(input seq_t seq, input logic [2:0] idx,
			input logic [ADDR_W-1:0] addr, input logic [7:0] data,
			input logic [1:0] status);
		res_t rd;
		res_t dn;
		res_t r;
		rd = '{kind: K_READ, addr: addr, data: 8'h00, status: ST_OK};
		dn = '{kind: K_DONE, addr: addr, data: 8'h00, status: status};
		r  = dn;
		unique case (seq)
			SEQ_DONE:   r = dn;
			SEQ_READ:   r = rd;
			SEQ_WRDONE: r = (idx == 3'd0) ? wr(A_ZERO, D_RESET) : dn;
			SEQ_PROG: begin
				case (idx)
					3'd0:    r = wr(A_UNLOCK1, D_UNLOCK1);
					3'd1:    r = wr(A_UNLOCK2, D_UNLOCK2);
					3'd2:    r = wr(A_UNLOCK1, D_PROGRAM);
					3'd3:    r = wr(addr, data);
					default: r = rd;
				endcase
			end
			SEQ_ERASE_RD, SEQ_ERASE_TO: begin
				case (idx)
					3'd0:    r = wr(A_ZERO, D_RESET);
					3'd1:    r = wr(A_UNLOCK1, D_UNLOCK1);
					3'd2:    r = wr(A_UNLOCK2, D_UNLOCK2);
					3'd3:    r = wr(A_UNLOCK1, D_ERASE);
					3'd4:    r = wr(A_UNLOCK1, D_UNLOCK1);
					3'd5:    r = wr(A_UNLOCK2, D_UNLOCK2);
					3'd6:    r = wr(addr, D_SECTOR);
					default: r = (seq == SEQ_ERASE_RD) ? rd : dn;
				endcase
			end
			default: r = dn;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/nfps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfps_core
// Input register, operation state and decode of each item into a result
// sequence for the emitter.
// ----------------------------------------------------------------------------
module nfps_core import nfps_pkg::*; #(
	parameter int ADDR_BITS = NFPS_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [1:0]         s_tuser,
	input  logic [39:0]        s_tdata,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	input  logic               free,
	output req_t               req
);

	localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

	logic               s1_valid_s1;
	logic [1:0]         cmd_s1;
	logic [AW-1:0]      addr_s1;
	logic [7:0]         wbyte_s1;
	logic [7:0]         rbyte_s1;

	phase_t             phase_q, phase_d;
	logic [AW-1:0]      poll_addr_q, poll_addr_d;
	logic               exp_bit_q, exp_bit_d;
	logic [LIMIT_W-1:0] attempt_q, attempt_d;
	logic [LIMIT_W-1:0] limit_q;

	logic               accept;
	logic               advance;
	logic               match;
	logic [LIMIT_W-1:0] attempt_inc;

	assign s_tready = !s1_valid_s1 || free;
	assign accept   = s_tvalid && s_tready;
	assign advance  = s1_valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (free) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= s_tuser;
			addr_s1  <= s_tdata[AW-1:0];
			wbyte_s1 <= s_tdata[28:21];
			rbyte_s1 <= s_tdata[36:29];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			poll_addr_q <= '0;
			exp_bit_q   <= 1'b0;
			attempt_q   <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			poll_addr_q <= poll_addr_d;
			exp_bit_q   <= exp_bit_d;
			attempt_q   <= attempt_d;
		end
	end

	assign match       = (rbyte_s1[7] == exp_bit_q);
	// attempt count saturates at all ones
	assign attempt_inc = (attempt_q == '1) ? attempt_q : attempt_q + 1'b1;

	always_comb begin
		phase_d     = phase_q;
		poll_addr_d = poll_addr_q;
		exp_bit_d   = exp_bit_q;
		attempt_d   = attempt_q;
		req.vld     = advance;
		req.emit    = 1'b1;
		req.seq     = SEQ_DONE;
		req.status  = ST_OK;
		req.addr    = ADDR_W'(poll_addr_q);
		req.data    = wbyte_s1;
		unique case (cmd_s1)
			CMD_PROG: begin
				req.addr = ADDR_W'(addr_s1);
				if (wbyte_s1 == D_ERASED) begin
					phase_d = PH_IDLE;
				end else begin
					req.seq     = SEQ_PROG;
					poll_addr_d = addr_s1;
					exp_bit_d   = wbyte_s1[7];
					phase_d     = PH_PROG_POLL;
				end
			end
			CMD_ERASE: begin
				req.addr    = ADDR_W'(addr_s1);
				poll_addr_d = addr_s1;
				attempt_d   = '0;
				if (limit_q == '0) begin
					req.seq    = SEQ_ERASE_TO;
					req.status = ST_TIMEOUT;
					phase_d    = PH_IDLE;
				end else begin
					req.seq = SEQ_ERASE_RD;
					phase_d = PH_ERASE_POLL;
				end
			end
			CMD_RESET: begin
				req.seq  = SEQ_WRDONE;
				req.addr = A_ZERO;
				phase_d  = PH_IDLE;
			end
			CMD_REPLY: begin
				unique case (phase_q)
					PH_PROG_POLL: begin
						if (match) begin
							phase_d = PH_IDLE;
						end else begin
							req.seq = SEQ_READ;
							if (rbyte_s1[5]) begin
								phase_d = PH_PROG_LAST;
							end
						end
					end
					PH_PROG_LAST: begin
						if (!match) begin
							req.seq    = SEQ_WRDONE;
							req.status = ST_FAIL;
						end
						phase_d = PH_IDLE;
					end
					PH_ERASE_POLL: begin
						attempt_d = attempt_inc;
						if (rbyte_s1 == D_ERASED) begin
							phase_d = PH_IDLE;
						end else if (attempt_inc >= limit_q) begin
							req.status = ST_TIMEOUT;
							phase_d    = PH_IDLE;
						end else begin
							req.seq = SEQ_READ;
						end
					end
					default: begin
						// reply with nothing outstanding
						req.emit = 1'b0;
					end
				endcase
			end
			default: req.emit = 1'b0;
		endcase
	end

endmodule

>>> hdl/nfps_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfps_emit
// Holds one decoded sequence and hands out its results, one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module nfps_emit import nfps_pkg::*; #(
	parameter int ADDR_BITS = NFPS_ADDR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  req_t        req,
	output logic        free,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [1:0]  m_tuser,
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	localparam int AW = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

	logic          busy_q;
	seq_t          seq_q;
	logic [2:0]    idx_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    data_q;
	logic [1:0]    status_q;

	logic          last;
	res_t          res;

	assign last = ({1'b0, idx_q} == (seq_len(seq_q) - 4'd1));
	assign free = !busy_q || (m_tready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (free) begin
			busy_q <= req.vld && req.emit;
			idx_q  <= '0;
		end else if (m_tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && req.vld) begin
			seq_q    <= req.seq;
			addr_q   <= req.addr[AW-1:0];
			data_q   <= req.data;
			status_q <= req.status;
		end
	end

	assign res      = seq_entry(seq_q, idx_q, ADDR_W'(addr_q), data_q, status_q);
	assign m_tvalid = busy_q;
	assign m_tuser  = res.kind;
	assign m_tdata  = {1'b0, res.status, res.data, res.addr};
	assign m_tlast  = last;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < seq_len(seq_q)))
		else $error("result index past end of sequence");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && m_tready && !last) |=> (busy_q && idx_q == $past(idx_q) + 3'd1))
		else $error("sequence did not advance by one result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !m_tready) |=> (busy_q && $stable(idx_q) && $stable(seq_q)))
		else $error("sequence changed while stalled");

endmodule

>>> hdl/nor_flash_program_erase_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nor_flash_program_erase_sequencer
// Host-side program/erase command sequencer for a byte-wide parallel NOR flash.
// ----------------------------------------------------------------------------
// Each item is a program, sector erase, reset or read reply. It is registered,
// decoded combinationally into a result sequence and handed to the emitter,
// which drives one result per cycle on the master side while m_tready is high:
// a reply gives at most one or two results, a reset two, a program five (one
// when the byte is already 0xFF) and an erase eight. The emitter port sets the
// rate: an item occupies it until all of its results are taken, and the next
// item is taken while the last result of the previous one is delivered. Replies
// while no operation is pending give no result. The poll limit register is
// written via cfg_we.
module nor_flash_program_erase_sequencer import nfps_pkg::*; #(
	parameter int ADDR_BITS = NFPS_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [1:0]         s_tuser,   // cmd
	input  logic [39:0]        s_tdata,   // target_addr, write_byte, read_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [1:0]         m_tuser,   // kind
	output logic [31:0]        m_tdata,   // bus_addr, bus_data, status
	output logic               m_tlast,   // last
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata  // erase_poll_limit
);

	req_t req;
	logic free;

	nfps_core #(
		.ADDR_BITS(ADDR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.free      (free),
		.req       (req)
	);

	nfps_emit #(
		.ADDR_BITS(ADDR_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the NOR flash program/erase sequencer.
// ----------------------------------------------------------------------------
// Drives program, sector erase, reset and read-reply items on the slave
// stream. The testbench predicts the ordered bus writes, bus reads and
// completions and compares each result on the master stream field by field.
// It runs directed cases, several poll limit settings and random well-formed
// operations with noise, under mixes of sender idling and receiver stalls.
// One long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;
	import nfps_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int CFG_SETTLE  = 16;
	localparam int DRAIN_WAIT  = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_SHOWN   = 10;
	localparam int DATA_LSB    = ADDR_W;
	localparam int STATUS_LSB  = ADDR_W + 8;
	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
		logic [1:0]        status;
		logic              last;
	} bus_op_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [1:0]         s_tuser   = '0;
	logic [39:0]        s_tdata   = '0;
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [1:0]         m_tuser;
	logic [31:0]        m_tdata;
	logic               m_tlast;
	logic               cfg_we    = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	// predicted sequencer state
	phase_t             pred_phase        = PH_IDLE;
	logic [ADDR_W-1:0]  pred_poll_addr    = '0;
	logic               pred_top_bit      = 1'b0;
	logic               pred_timeout_seen = 1'b0;
	logic [15:0]        pred_attempts     = '0;
	logic [LIMIT_W-1:0] pred_limit        = LIMIT_RESET;

	bus_op_t bus_ops_due[$];

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	bit rx_hold      = 1'b0;
	int err_count    = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int n_ok         = 0;
	int n_fail       = 0;
	int n_timeout    = 0;
	int limits_used  = 0;
	int cycle_count  = 0;

	nor_flash_program_erase_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				bus_ops_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, or held off entirely during the pressure test
	always @(negedge clk) begin
		if (rx_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	function automatic bus_op_t bus_op(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
			input logic [7:0] data, input logic [1:0] status);
		bus_op_t op;
		op.kind   = kind;
		op.addr   = addr;
		op.data   = data;
		op.status = status;
		op.last   = 1'b0;
		return op;
	endfunction

	task automatic predict_bus_ops(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic [7:0] wb, input logic [7:0] rb);
		bus_op_t ops[$];
		bus_op_t op;
		logic    match;
		match = (rb[7] == pred_top_bit);
		case (cmd)
			CMD_PROG: begin
				pred_phase = PH_IDLE;
				if (wb == D_ERASED) begin
					// erased value already there, nothing to program
					ops.push_back(bus_op(K_DONE, addr, 8'h00, ST_OK));
				end else begin
					ops.push_back(bus_op(K_WRITE, A_UNLOCK1, D_UNLOCK1, ST_OK));
					ops.push_back(bus_op(K_WRITE, A_UNLOCK2, D_UNLOCK2, ST_OK));
					ops.push_back(bus_op(K_WRITE, A_UNLOCK1, D_PROGRAM, ST_OK));
					ops.push_back(bus_op(K_WRITE, addr, wb, ST_OK));
					ops.push_back(bus_op(K_READ, addr, 8'h00, ST_OK));
					pred_poll_addr = addr;
					pred_top_bit   = wb[7];
					pred_phase     = PH_PROG_POLL;
				end
			end
			CMD_ERASE: begin
				ops.push_back(bus_op(K_WRITE, A_ZERO, D_RESET, ST_OK));
				ops.push_back(bus_op(K_WRITE, A_UNLOCK1, D_UNLOCK1, ST_OK));
				ops.push_back(bus_op(K_WRITE, A_UNLOCK2, D_UNLOCK2, ST_OK));
				ops.push_back(bus_op(K_WRITE, A_UNLOCK1, D_ERASE, ST_OK));
				ops.push_back(bus_op(K_WRITE, A_UNLOCK1, D_UNLOCK1, ST_OK));
				ops.push_back(bus_op(K_WRITE, A_UNLOCK2, D_UNLOCK2, ST_OK));
				ops.push_back(bus_op(K_WRITE, addr, D_SECTOR, ST_OK));
				pred_poll_addr    = addr;
				pred_attempts     = '0;
				pred_timeout_seen = 1'b0;
				if (pred_limit == '0) begin
					pred_timeout_seen = 1'b1;
					ops.push_back(bus_op(K_DONE, addr, 8'h00, ST_TIMEOUT));
					pred_phase = PH_IDLE;
				end else begin
					ops.push_back(bus_op(K_READ, addr, 8'h00, ST_OK));
					pred_phase = PH_ERASE_POLL;
				end
			end
			CMD_RESET: begin
				pred_phase = PH_IDLE;
				ops.push_back(bus_op(K_WRITE, A_ZERO, D_RESET, ST_OK));
				ops.push_back(bus_op(K_DONE, A_ZERO, 8'h00, ST_OK));
			end
			default: begin
				case (pred_phase)
					PH_PROG_POLL: begin
						if (match) begin
							ops.push_back(bus_op(K_DONE, pred_poll_addr, 8'h00, ST_OK));
							pred_phase = PH_IDLE;
						end else begin
							ops.push_back(bus_op(K_READ, pred_poll_addr, 8'h00, ST_OK));
							// dq5 set: exceeded time limit, one last read decides
							if (rb[5])
								pred_phase = PH_PROG_LAST;
						end
					end
					PH_PROG_LAST: begin
						if (match) begin
							ops.push_back(bus_op(K_DONE, pred_poll_addr, 8'h00, ST_OK));
						end else begin
							ops.push_back(bus_op(K_WRITE, A_ZERO, D_RESET, ST_OK));
							ops.push_back(bus_op(K_DONE, pred_poll_addr, 8'h00, ST_FAIL));
						end
						pred_phase = PH_IDLE;
					end
					PH_ERASE_POLL: begin
						if (pred_attempts != 16'hFFFF)
							pred_attempts++;
						if (rb == D_ERASED) begin
							ops.push_back(bus_op(K_DONE, pred_poll_addr, 8'h00, ST_OK));
							pred_phase = PH_IDLE;
						end else if (pred_attempts >= pred_limit) begin
							pred_timeout_seen = 1'b1;
							ops.push_back(bus_op(K_DONE, pred_poll_addr, 8'h00, ST_TIMEOUT));
							pred_phase = PH_IDLE;
						end else begin
							ops.push_back(bus_op(K_READ, pred_poll_addr, 8'h00, ST_OK));
						end
					end
					default: ;
				endcase
			end
		endcase
		foreach (ops[i]) begin
			op      = ops[i];
			op.last = (i == ops.size() - 1);
			bus_ops_due.push_back(op);
		end
	endtask

	task automatic report_error(input string what, input bus_op_t want, input bus_op_t got);
		err_count++;
		if (err_count <= MAX_SHOWN) begin
			$display("%0t %s: expected kind %0d addr %h data %h status %0d last %b",
				$realtime, what, want.kind, want.addr, want.data, want.status, want.last);
			$display("%0t %s: got      kind %0d addr %h data %h status %0d last %b",
				$realtime, what, got.kind, got.addr, got.data, got.status, got.last);
		end
	endtask

	always @(posedge clk) begin
		bus_op_t got;
		bus_op_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[ADDR_W-1:0], m_tdata[DATA_LSB+7:DATA_LSB],
				m_tdata[STATUS_LSB+1:STATUS_LSB], m_tlast};
			results_seen++;
			if (bus_ops_due.size() == 0) begin
				report_error("result with nothing pending", '0, got);
			end else begin
				want = bus_ops_due.pop_front();
				if (got !== want)
					report_error("mismatch", want, got);
				else if (want.kind == K_DONE) begin
					case (want.status)
						ST_OK:   n_ok++;
						ST_FAIL: n_fail++;
						default: n_timeout++;
					endcase
				end
			end
		end
	end

	// called and returns at a falling edge
	task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic [7:0] wb, input logic [7:0] rb);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, rb, wb, addr};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		predict_bus_ops(cmd, addr, wb, rb);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (bus_ops_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_poll_limit(input logic [LIMIT_W-1:0] value);
		wait_drain();
		// a trailing ignored reply may still be inside the block
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we     <= 1'b0;
		pred_limit  = value;
		limits_used++;
	endtask

	function automatic logic [ADDR_W-1:0] rand_addr();
		int pick;
		pick = $urandom_range(7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return ADDR_MAX;
		return ADDR_W'($urandom);
	endfunction

	// steer replies toward the interesting outcomes of the pending operation
	function automatic logic [7:0] shape_reply(input logic [7:0] raw);
		logic [7:0] rb;
		int         pick;
		rb   = raw;
		pick = $urandom_range(99);
		case (pred_phase)
			PH_PROG_POLL:  rb[7] = (pick < 40) ? pred_top_bit : ~pred_top_bit;
			PH_PROG_LAST:  rb[7] = (pick < 50) ? pred_top_bit : ~pred_top_bit;
			PH_ERASE_POLL: if (pick < 30) rb = D_ERASED;
			default: ;
		endcase
		return rb;
	endfunction

	task automatic send_random_op(output bit counted);
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wb;
		logic [7:0]        rb;
		int                pick;
		pick = $urandom_range(99);
		addr = rand_addr();
		wb   = 8'($urandom);
		rb   = 8'($urandom);
		if (pred_phase == PH_IDLE)
			cmd = (pick < 45) ? CMD_PROG : (pick < 80) ? CMD_ERASE :
				(pick < 90) ? CMD_RESET : CMD_REPLY;
		else
			cmd = (pick < 85) ? CMD_REPLY : (pick < 92) ? CMD_PROG :
				(pick < 97) ? CMD_ERASE : CMD_RESET;
		if (cmd == CMD_PROG && $urandom_range(9) == 0)
			wb = D_ERASED;
		if (cmd == CMD_REPLY)
			rb = shape_reply(rb);
		counted = !(cmd == CMD_REPLY && pred_phase == PH_IDLE);
		send_item(cmd, addr, wb, rb);
	endtask

	task automatic test_directed_program();
		tx_idle_pct  = 0;
		rx_stall_pct = 25;
		// erased byte needs no bus traffic
		send_item(CMD_PROG, ADDR_MAX, D_ERASED, 8'h00);
		// poll: no match, then dq5, then still no match -> failure
		send_item(CMD_PROG, '0, 8'h00, 8'hFF);
		send_item(CMD_REPLY, ADDR_MAX, 8'hFF, 8'h80);
		send_item(CMD_REPLY, '0, 8'h00, 8'hA0);
		send_item(CMD_REPLY, '0, 8'h00, 8'hFF);
		// dq5 then match on the last read -> success
		send_item(CMD_PROG, 21'h155555, 8'h80, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'h7F);
		send_item(CMD_REPLY, '0, 8'h00, 8'h80);
		// direct match
		send_item(CMD_PROG, 21'h0AAAAA, 8'h5A, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'h00);
	endtask

	task automatic test_directed_erase_reset();
		send_item(CMD_ERASE, ADDR_MAX, 8'h00, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'hFE);
		send_item(CMD_REPLY, '0, 8'h00, 8'hFF);
		send_item(CMD_RESET, ADDR_MAX, 8'hFF, 8'hFF);
		// reply with no operation pending is dropped
		send_item(CMD_REPLY, ADDR_MAX, 8'hFF, 8'h00);
		// a new command abandons the pending one
		send_item(CMD_PROG, 21'h012345, 8'h33, 8'h00);
		send_item(CMD_ERASE, 21'h1F0000, 8'h00, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'hFF);
		send_item(CMD_ERASE, 21'h010000, 8'h00, 8'h00);
		send_item(CMD_PROG, 21'h010001, 8'h01, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'h01);
	endtask

	task automatic test_poll_limits();
		set_poll_limit(16'd1);
		send_item(CMD_ERASE, 21'h020000, 8'h00, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'h00);
		// zero budget times out right after the erase sequence
		set_poll_limit(16'd0);
		send_item(CMD_ERASE, 21'h030000, 8'h00, 8'h00);
		set_poll_limit(16'd2);
		send_item(CMD_ERASE, 21'h040000, 8'h00, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'h12);
		send_item(CMD_REPLY, '0, 8'h00, 8'h34);
		set_poll_limit(16'hFFFF);
		send_item(CMD_ERASE, 21'h050000, 8'h00, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'h00);
		send_item(CMD_REPLY, '0, 8'h00, 8'hFF);
	endtask

	task automatic test_random(input int tx_pct, input int rx_pct,
			input logic [LIMIT_W-1:0] limit, input int n_items);
		int done;
		bit counted;
		set_poll_limit(limit);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		done = 0;
		while (done < n_items) begin
			send_random_op(counted);
			if (counted)
				done++;
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		bit counted;
		set_poll_limit(LIMIT_RESET);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold      = 1'b1;
		fork
			begin
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
		join_none
		repeat (16)
			send_random_op(counted);
		wait_drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_program();
		test_directed_erase_reset();
		test_poll_limits();
		test_random(0, 0, 16'd3, 40);
		test_random(76, 0, 16'd1, 40);
		test_random(0, 76, 16'hFFFF, 40);
		test_random(10, 10, LIMIT_W'($urandom_range(2, 6)), 40);
		test_backpressure();

		wait_drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("summary: %0d items, %0d results, %0d ok, %0d program fail, %0d timeout",
			items_sent, results_seen, n_ok, n_fail, n_timeout);
		$display("summary: %0d poll limit writes, idle/stall mixes, one hold-off, %0d errors",
			limits_used, err_count);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
